[sv/pbd_pkg.sv]
// ----------------------------------------------------------------------------
// Prior box decode package
// Shared widths, register indexes, pipeline depth and the exponent table.
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int PIPE_STAGES = 8;

   localparam int REQ_TDATA_W = 176;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECTNESS_THR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_THR      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VAR_CENTER_X   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VAR_CENTER_Y   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VAR_WIDTH      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VAR_HEIGHT     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd7;

   localparam logic [15:0] RST_OBJECTNESS_THR = 16'd16384;
   localparam logic [15:0] RST_CLASS_THR      = 16'd16384;
   localparam logic [15:0] RST_VAR_CENTER     = 16'd3277;
   localparam logic [15:0] RST_VAR_SIZE       = 16'd6554;
   localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd672;
   localparam logic [11:0] RST_IMAGE_HEIGHT   = 12'd384;

   // Exponent table: entry k holds 2^(k/depth) in Q1.30.
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
   localparam int EXP_ROM_W       = 31;
   localparam logic [EXP_IDX_W:0] EXP_DEPTH_K = (EXP_IDX_W + 1)'(EXP_TABLE_DEPTH);

   localparam logic [63:0]        LN2_Q30   = 64'd744261118;
   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

   typedef logic [EXP_ROM_W-1:0] exp_rom_type [EXP_TABLE_DEPTH];

   // Restoring long division, used only while the table is built.
   function automatic logic [63:0] long_divide(input logic [63:0] num,
                                               input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] x;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] n;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         x    = long_divide(64'(k) * LN2_Q30, 64'(EXP_TABLE_DEPTH));
         sum  = 64'd1 << 30;
         term = 64'd1 << 30;
         n    = 64'd1;
         while (term != 64'd0 && n < 64'd64) begin
            term = long_divide((term * x) >> 30, n);
            sum  = sum + term;
            n    = n + 64'd1;
         end
         rom[k] = sum[EXP_ROM_W-1:0];
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

[sv/pbd_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// Prior box decode pipeline control
// Valid bits per stage and a ready chain that lets bubbles collapse.
// ----------------------------------------------------------------------------
module pbd_pipe_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic                             in_keep,
   input  logic                             out_ready,
   output logic                             in_ready,
   output logic [pbd_pkg::PIPE_STAGES-1:0]  stage_en,
   output logic                             out_valid
);
   import pbd_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES:0]   ready;

   always_comb begin
      ready[PIPE_STAGES] = out_ready;
      for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign stage_en  = ready[PIPE_STAGES-1:0];
   assign valid_in  = {valid_ff[PIPE_STAGES-2:0], in_valid && in_keep};
   assign in_ready  = ready[0];
   assign out_valid = valid_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

endmodule

[sv/pbd_axis.sv]
// ----------------------------------------------------------------------------
// Prior box decode axis datapath
// Decodes centre and size of one axis and scales them to saturated pixels.
// ----------------------------------------------------------------------------
module pbd_axis (
   input  logic                             clock,
   input  logic [pbd_pkg::PIPE_STAGES-1:0]  stage_en,
   input  logic [15:0]                      prior_lo,
   input  logic [15:0]                      prior_hi,
   input  logic signed [15:0]               delta_center,
   input  logic signed [15:0]               delta_log,
   input  logic [15:0]                      variance_center,
   input  logic [15:0]                      variance_log,
   input  logic [11:0]                      image_dim,
   output logic signed [15:0]               box_edge,
   output logic [15:0]                      box_len
);
   import pbd_pkg::*;

   localparam logic [61:0]        SIZE_LIMIT = 62'd1 << 50;
   localparam logic signed [65:0] EDGE_BIAS  = 66'sh1_FFFF_FFFF;

   logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h;

   assign {en_h, en_g, en_f, en_e, en_d, en_c, en_b, en_a} = stage_en;

   // Stage A
   logic signed [16:0] size_in, size_a_ff;
   logic [16:0]        sum_in, sum_a_ff;
   logic signed [32:0] pc_in, pc_a_ff;
   logic signed [32:0] la_in, la_a_ff;

   always_comb begin
      size_in = $signed({1'b0, prior_hi}) - $signed({1'b0, prior_lo});
      sum_in  = {1'b0, prior_lo} + {1'b0, prior_hi};
      pc_in   = delta_center * $signed({1'b0, variance_center});
      la_in   = delta_log * $signed({1'b0, variance_log});
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         size_a_ff <= size_in;
         sum_a_ff  <= sum_in;
         pc_a_ff   <= pc_in;
         la_a_ff   <= la_in;
      end
   end

   // Stage B
   logic signed [49:0] cprod_in, cprod_b_ff;
   logic signed [64:0] ta_in, ta_b_ff;
   logic signed [16:0] size_b_ff;
   logic [16:0]        sum_b_ff;

   always_comb begin
      cprod_in = pc_a_ff * size_a_ff;
      ta_in    = la_a_ff * LOG2E_Q30;
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         cprod_b_ff <= cprod_in;
         ta_b_ff    <= ta_in;
         size_b_ff  <= size_a_ff;
         sum_b_ff   <= sum_a_ff;
      end
   end

   // Stage C
   logic signed [49:0]       c_full;
   logic signed [40:0]       c_in, c_c_ff;
   logic [29:0]              frac;
   logic [30+EXP_IDX_W:0]    idx_prod;
   logic [EXP_IDX_W-1:0]     idx;
   logic [EXP_ROM_W-1:0]     m_in, m_c_ff;
   logic signed [7:0]        ip_c_ff;
   logic [15:0]              sizemag_in, sizemag_c_ff;
   logic                     neg_c_ff;

   always_comb begin
      c_full     = (cprod_b_ff >>> 10) + $signed({17'd0, sum_b_ff, 16'd0});
      c_in       = c_full[40:0];
      frac       = ta_b_ff[56:27];
      idx_prod   = frac * EXP_DEPTH_K;
      idx        = idx_prod[30 +: EXP_IDX_W];
      m_in       = EXP_ROM[idx];
      sizemag_in = size_b_ff[16] ? 16'(-size_b_ff) : size_b_ff[15:0];
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_c_ff       <= c_in;
         m_c_ff       <= m_in;
         ip_c_ff      <= ta_b_ff[64:57];
         sizemag_c_ff <= sizemag_in;
         neg_c_ff     <= size_b_ff[16];
      end
   end

   // Stage D
   logic [46:0]        magp_in, magp_d_ff;
   logic signed [40:0] c_d_ff;
   logic signed [7:0]  ip_d_ff;
   logic               neg_d_ff;

   assign magp_in = sizemag_c_ff * m_c_ff;

   always_ff @(posedge clock) begin
      if (en_d) begin
         magp_d_ff <= magp_in;
         c_d_ff    <= c_c_ff;
         ip_d_ff   <= ip_c_ff;
         neg_d_ff  <= neg_c_ff;
      end
   end

   // Stage E: scale by the integer power of two and clamp.
   logic [7:0]         sh_r;
   logic [7:0]         sh_l;
   logic [46:0]        right;
   logic [61:0]        left;
   logic [61:0]        wide;
   logic [50:0]        smag_in, smag_e_ff;
   logic signed [40:0] c_e_ff;
   logic               neg_e_ff;

   always_comb begin
      sh_r  = 8'd13 - ip_d_ff;
      sh_l  = ip_d_ff - 8'sd13;
      right = magp_d_ff >> sh_r;
      left  = {15'd0, magp_d_ff} << sh_l[3:0];
      if (ip_d_ff <= 8'sd13) begin
         wide = {15'd0, right};
      end else if (sh_l >= 8'd16) begin
         wide = (magp_d_ff != '0) ? SIZE_LIMIT : '0;
      end else begin
         wide = left;
      end
      smag_in = (wide > SIZE_LIMIT) ? SIZE_LIMIT[50:0] : wide[50:0];
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         smag_e_ff <= smag_in;
         c_e_ff    <= c_d_ff;
         neg_e_ff  <= neg_d_ff;
      end
   end

   // Stage F
   logic signed [52:0] twoc;
   logic signed [52:0] smag_s;
   logic signed [52:0] diff_in, diff_f_ff;
   logic [50:0]        smag_f_ff;
   logic               neg_f_ff;

   always_comb begin
      twoc    = $signed({{11{c_e_ff[40]}}, c_e_ff, 1'b0});
      smag_s  = $signed({2'b00, smag_e_ff});
      diff_in = neg_e_ff ? (twoc + smag_s) : (twoc - smag_s);
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         diff_f_ff <= diff_in;
         smag_f_ff <= smag_e_ff;
         neg_f_ff  <= neg_e_ff;
      end
   end

   // Stage G
   logic signed [65:0] pe_in, pe_g_ff;
   logic [62:0]        pl_in, pl_g_ff;
   logic               neg_g_ff;

   always_comb begin
      pe_in = diff_f_ff * $signed({1'b0, image_dim});
      pl_in = smag_f_ff * image_dim;
   end

   always_ff @(posedge clock) begin
      if (en_g) begin
         pe_g_ff  <= pe_in;
         pl_g_ff  <= pl_in;
         neg_g_ff <= neg_f_ff;
      end
   end

   // Stage H: truncate toward zero and saturate.
   logic signed [65:0] biased;
   logic signed [32:0] q_edge;
   logic [30:0]        q_len;
   logic signed [15:0] edge_in, edge_h_ff;
   logic [15:0]        len_in, len_h_ff;

   always_comb begin
      biased = pe_g_ff + (pe_g_ff[65] ? EDGE_BIAS : 66'sd0);
      q_edge = biased[65:33];
      q_len  = pl_g_ff[62:32];
      if (q_edge > 33'sd32767) begin
         edge_in = 16'sh7FFF;
      end else if (q_edge < -33'sd32768) begin
         edge_in = 16'sh8000;
      end else begin
         edge_in = q_edge[15:0];
      end
      if (neg_g_ff) begin
         len_in = '0;
      end else if (q_len > 31'd65535) begin
         len_in = 16'hFFFF;
      end else begin
         len_in = q_len[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_h) begin
         edge_h_ff <= edge_in;
         len_h_ff  <= len_in;
      end
   end

   assign box_edge = edge_h_ff;
   assign box_len  = len_h_ff;

endmodule

[sv/prior_box_detection_decode_core.sv]
// ----------------------------------------------------------------------------
// Prior box detection decoder
// Filters priors by score and decodes kept ones into integer pixel boxes.
// ----------------------------------------------------------------------------
// Usage:
// Each req beat carries one prior with its scores, deltas and corners. A
// prior whose objectness or best class score is below its threshold is
// consumed and produces no rsp beat; a kept prior produces exactly one rsp
// beat with the winning class in tuser and the pixel box in tdata.
// The datapath is an eight stage pipeline, so a kept prior appears on rsp
// once it has passed every stage register. Each stage holds one beat, and
// a new beat is taken every cycle unless a stall has filled every stage.
// When the receiver holds rsp_tready low the final stage holds its beat and
// empty stages behind it keep filling, so req_tready falls only once every
// stage is occupied. Reset clears all stage valid bits and returns the
// registers to their defaults. The user must write the registers through the
// csr port only while no beats are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module prior_box_detection_decode_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // objectness, score_class_zero, score_class_one, delta_center_x,
   // delta_center_y, delta_log_width, delta_log_height, prior_left,
   // prior_top, prior_right, prior_bottom
   input  logic [pbd_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // class_score, box_x, box_y, box_width, box_height
   output logic [pbd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // class_index
   output logic [pbd_pkg::RSP_TUSER_W-1:0]       rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_wen,
   input  logic [pbd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import pbd_pkg::*;

   logic [15:0] obj_thr_ff, cls_thr_ff;
   logic [15:0] var_cx_ff, var_cy_ff, var_w_ff, var_h_ff;
   logic [11:0] img_w_ff, img_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_thr_ff <= RST_OBJECTNESS_THR;
         cls_thr_ff <= RST_CLASS_THR;
         var_cx_ff  <= RST_VAR_CENTER;
         var_cy_ff  <= RST_VAR_CENTER;
         var_w_ff   <= RST_VAR_SIZE;
         var_h_ff   <= RST_VAR_SIZE;
         img_w_ff   <= RST_IMAGE_WIDTH;
         img_h_ff   <= RST_IMAGE_HEIGHT;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_OBJECTNESS_THR: obj_thr_ff <= csr_wdata;
            CSR_CLASS_THR:      cls_thr_ff <= csr_wdata;
            CSR_VAR_CENTER_X:   var_cx_ff  <= csr_wdata;
            CSR_VAR_CENTER_Y:   var_cy_ff  <= csr_wdata;
            CSR_VAR_WIDTH:      var_w_ff   <= csr_wdata;
            CSR_VAR_HEIGHT:     var_h_ff   <= csr_wdata;
            CSR_IMAGE_WIDTH:    img_w_ff   <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT:   img_h_ff   <= csr_wdata[11:0];
            default: begin
            end
         endcase
      end
   end

   logic [15:0]        objectness, score_zero, score_one;
   logic signed [15:0] delta_cx, delta_cy, delta_lw, delta_lh;
   logic [15:0]        prior_left, prior_top, prior_right, prior_bottom;

   assign objectness   = req_tdata[15:0];
   assign score_zero   = req_tdata[31:16];
   assign score_one    = req_tdata[47:32];
   assign delta_cx     = req_tdata[63:48];
   assign delta_cy     = req_tdata[79:64];
   assign delta_lw     = req_tdata[95:80];
   assign delta_lh     = req_tdata[111:96];
   assign prior_left   = req_tdata[127:112];
   assign prior_top    = req_tdata[143:128];
   assign prior_right  = req_tdata[159:144];
   assign prior_bottom = req_tdata[175:160];

   // Ties go to class zero.
   logic        cls_in;
   logic [15:0] score_in;
   logic        keep;

   always_comb begin
      cls_in   = score_one > score_zero;
      score_in = cls_in ? score_one : score_zero;
      keep     = (objectness >= obj_thr_ff) && (score_in >= cls_thr_ff);
   end

   logic [PIPE_STAGES-1:0] stage_en;

   pbd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_keep   (keep),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .stage_en  (stage_en),
      .out_valid (rsp_tvalid)
   );

   logic        cls_ff   [PIPE_STAGES];
   logic [15:0] score_ff [PIPE_STAGES];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cls_ff[0]   <= cls_in;
         score_ff[0] <= score_in;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
         if (stage_en[i]) begin
            cls_ff[i]   <= cls_ff[i-1];
            score_ff[i] <= score_ff[i-1];
         end
      end
   end

   logic signed [15:0] box_x, box_y;
   logic [15:0]        box_width, box_height;

   pbd_axis u_axis_x (
      .clock           (clock),
      .stage_en        (stage_en),
      .prior_lo        (prior_left),
      .prior_hi        (prior_right),
      .delta_center    (delta_cx),
      .delta_log       (delta_lw),
      .variance_center (var_cx_ff),
      .variance_log    (var_w_ff),
      .image_dim       (img_w_ff),
      .box_edge        (box_x),
      .box_len         (box_width)
   );

   pbd_axis u_axis_y (
      .clock           (clock),
      .stage_en        (stage_en),
      .prior_lo        (prior_top),
      .prior_hi        (prior_bottom),
      .delta_center    (delta_cy),
      .delta_log       (delta_lh),
      .variance_center (var_cy_ff),
      .variance_log    (var_h_ff),
      .image_dim       (img_h_ff),
      .box_edge        (box_y),
      .box_len         (box_height)
   );

   assign rsp_tdata = {box_height, box_width, box_y, box_x, score_ff[PIPE_STAGES-1]};
   assign rsp_tuser = cls_ff[PIPE_STAGES-1];

endmodule

[sv/pbd_checker.sv]
// ----------------------------------------------------------------------------
// Prior box decode port checker
// Watches the top level ports for reset, stall and flow behaviour.
// ----------------------------------------------------------------------------
module pbd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [pbd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [pbd_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready
);
   import pbd_pkg::*;

   // The pipeline is empty straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat present after reset");

   // A stalled result beat holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   // With the receiver ready the pipeline never pushes back.
   assert property (@(posedge clock) disable iff (reset) rsp_tready |-> req_tready)
      else $error("req back-pressure without rsp stall");

   // A stalled pipeline only refuses input while it holds a result beat.
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("req refused while no rsp beat pending");

endmodule

bind prior_box_detection_decode_core pbd_checker u_pbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
